FILE: src/base64_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared concurrent assertion forms, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define B64_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64 assertion failed");
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64 assertion failed");
`else
`define B64_ASSERT_SAME(label, ante, cons)
`define B64_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// types, character codes and the symbol table of the base64 decoder
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [6:0] SYM_BAD = 7'd127;
  localparam logic [6:0] SYM_PAD = 7'd64;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            fin;
    logic            bad;
  } job_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_BAD;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == CH_PLUS) v = 7'd62;
    else if (c == CH_SLASH) v = 7'd63;
    else if (c == CH_PAD) v = SYM_PAD;
    return v;
  endfunction

endpackage

FILE: src/b64_ifs.sv
// ----------------------------------------------------------------------------
// b64 channel interfaces
// valid/ready channels for characters in and decoded results out
// ----------------------------------------------------------------------------
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       final_symbol;

  modport source (output valid, output symbol, output final_symbol, input ready);
  modport sink   (input valid, input symbol, input final_symbol, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       status;
  logic       last_result;

  modport source (output valid, output kind, output byte_value, output status,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input byte_value, input status,
                  input last_result, output ready);
endinterface

FILE: src/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 text decoder with per-message status
// ----------------------------------------------------------------------------
// in_chan carries one character per item with final_symbol on the last
// character of a message. out_chan carries decoded bytes (kind 0) as each
// group of four symbols completes, then one status result (kind 1) for the
// final character; last_result marks the final result of each input item.
// A message with status 1 is malformed and its bytes must be dropped.
// Each accepted item that yields results is written to the job queue, and
// its results then to the output register. Throughput: one character per
// cycle while the four-entry job queue has room; the output register emits
// one result per cycle while out_chan.ready is high, so an item completing
// a group yields up to three byte results, four with its status result.
// The queue refills the rate on characters that yield nothing (three of
// every four symbols). Reset (rst_n low, synchronous) clears the decoder
// state, the queue and the output valid flag. When the receiver stalls
// the output holds, the queue fills and in_chan.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_chan,
  b64_out_if.source out_chan
);
  import b64_pkg::*;

  job_t push_job;
  job_t head_job;
  logic job_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (push_job)
  );

  b64_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .wdata     (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (head_job),
    .not_empty (q_valid)
  );

  b64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head_job),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: src/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// accepts characters, tracks group and framing state, builds decode jobs
// ----------------------------------------------------------------------------
module b64_front (
  input  logic          clk,
  input  logic          rst_n,
  b64_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          job_push,
  output b64_pkg::job_t job
);
  import b64_pkg::*;

  logic [17:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_fill_r, group_fill_nxt;
  logic [1:0]  pads_seen_r,  pads_seen_nxt;
  logic        space_run_r,  space_run_nxt;
  logic        cr_wait_r,    cr_wait_nxt;
  logic        failed_r,     failed_nxt;
  logic        acc;
  logic [7:0]  c;
  logic [6:0]  v;
  logic [23:0] x;
  logic [1:0]  nb;

  assign c             = in_chan.symbol;
  assign v             = sextet_of(c);
  assign x             = {group_bits_r, v[5:0]};
  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && !q_full;

  always_comb begin
    group_bits_nxt = group_bits_r;
    group_fill_nxt = group_fill_r;
    pads_seen_nxt  = pads_seen_r;
    space_run_nxt  = space_run_r;
    cr_wait_nxt    = cr_wait_r;
    failed_nxt     = failed_r;
    nb             = 2'd0;
    if (!failed_r) begin
      if (cr_wait_r) begin
        if (c == CH_LF) begin
          cr_wait_nxt   = 1'b0;
          space_run_nxt = 1'b0;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (c == CH_SPACE) begin
        space_run_nxt = 1'b1;
      end else if (c == CH_CR) begin
        cr_wait_nxt   = 1'b1;
        space_run_nxt = 1'b0;
      end else if (c == CH_LF) begin
        space_run_nxt = 1'b0;
      end else if (space_run_r || v == SYM_BAD) begin
        failed_nxt = 1'b1;
      end else if (v == SYM_PAD && pads_seen_r >= 2'd2) begin
        failed_nxt = 1'b1;
      end else if (v != SYM_PAD && pads_seen_r != 2'd0) begin
        failed_nxt = 1'b1;
      end else begin
        if (v == SYM_PAD) pads_seen_nxt = pads_seen_r + 2'd1;
        if (group_fill_r != 2'd3) begin
          group_bits_nxt = {group_bits_r[11:0], v[5:0]};
          group_fill_nxt = group_fill_r + 2'd1;
        end else begin
          group_bits_nxt = '0;
          group_fill_nxt = 2'd0;
          nb             = 2'd3 - pads_seen_nxt;
        end
      end
    end
  end

  always_comb begin
    job.data[0] = x[23:16];
    job.data[1] = x[15:8];
    job.data[2] = x[7:0];
    job.nbytes  = nb;
    job.fin     = in_chan.final_symbol;
    job.bad     = failed_nxt || cr_wait_nxt;
    job_push    = acc && (nb != 2'd0 || in_chan.final_symbol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_chan.final_symbol)) begin
      group_bits_r <= '0;
      group_fill_r <= 2'd0;
      pads_seen_r  <= 2'd0;
      space_run_r  <= 1'b0;
      cr_wait_r    <= 1'b0;
      failed_r     <= 1'b0;
    end else if (acc) begin
      group_bits_r <= group_bits_nxt;
      group_fill_r <= group_fill_nxt;
      pads_seen_r  <= pads_seen_nxt;
      space_run_r  <= space_run_nxt;
      cr_wait_r    <= cr_wait_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

FILE: src/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// short first-in first-out buffer of decode jobs between front and back
// ----------------------------------------------------------------------------
module b64_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b64_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output b64_pkg::job_t rdata,
  output logic          not_empty
);
  import b64_pkg::*;

  job_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (QAW+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// expands each decode job into byte and status results, one per cycle while out_chan is ready
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module b64_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  b64_pkg::job_t head,
  output logic          q_pop,
  b64_out_if.source     out_chan
);
  import b64_pkg::*;

  logic [1:0] idx_r;
  logic [2:0] total;
  logic       load;
  logic       is_status;
  logic       out_valid_r;
  logic       kind_r;
  logic [7:0] byte_r;
  logic       status_r;
  logic       last_r;
  logic [7:0] sel_byte;

  assign total     = {1'b0, head.nbytes} + {2'b0, head.fin};
  assign is_status = idx_r == head.nbytes;
  assign load      = q_valid && (!out_valid_r || out_chan.ready);
  assign q_pop     = load && ({1'b0, idx_r} == total - 3'd1);

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = head.data[0];
      2'd1:    sel_byte = head.data[1];
      default: sel_byte = head.data[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) idx_r <= q_pop ? 2'd0 : idx_r + 2'd1;
      if (load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= is_status ? KIND_STATUS : KIND_DATA;
      byte_r   <= is_status ? 8'd0 : sel_byte;
      status_r <= is_status && head.bad;
      last_r   <= q_pop;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = kind_r;
  assign out_chan.byte_value  = byte_r;
  assign out_chan.status      = status_r;
  assign out_chan.last_result = last_r;

  `B64_ASSERT_SAME(a_status_is_last, out_valid_r && kind_r == KIND_STATUS, last_r)
  `B64_ASSERT_SAME(a_data_clean_status, out_valid_r && kind_r == KIND_DATA, !status_r)
  `B64_ASSERT_SAME(a_idx_in_job, q_valid, {1'b0, idx_r} < total)
  `B64_ASSERT_NEXT(a_pop_restarts, q_pop, idx_r == 2'd0)

endmodule
